FILE: rtl/reversing_motor_relay_sequencer_top_macros.svh
// assertion macros for the relay sequencer
`ifndef REVERSING_MOTOR_RELAY_SEQUENCER_TOP_MACROS_SVH
`define REVERSING_MOTOR_RELAY_SEQUENCER_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define RMRS_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rmrs assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define RMRS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rmrs assertion failed");

`endif

FILE: rtl/rmrs_pkg.sv
// shared types, codes and helpers of the relay sequencer
package rmrs_pkg;

    localparam int CHANNELS   = 3;
    localparam int TIMER_BITS = 22;

    localparam logic [31:0] TMAX = 32'((64'd1 << TIMER_BITS) - 64'd1);

    typedef logic [2:0]            mode_t;
    typedef logic [TIMER_BITS-1:0] timer_t;

    // channel modes
    localparam mode_t M_UNKNOWN   = 3'd0;
    localparam mode_t M_CLOSED    = 3'd1;
    localparam mode_t M_MOV_OPEN  = 3'd2;
    localparam mode_t M_OPEN      = 3'd3;
    localparam mode_t M_MOV_CLOSE = 3'd4;
    localparam mode_t M_GAP_OPEN  = 3'd5;
    localparam mode_t M_GAP_CLOSE = 3'd6;

    // sequence phases
    localparam logic [1:0] PH_BOOT   = 2'd0;
    localparam logic [1:0] PH_NORMAL = 2'd1;
    localparam logic [1:0] PH_GUARD  = 2'd2;
    localparam logic [1:0] PH_CALIB  = 2'd3;

    // command codes
    localparam logic [2:0] OP_TICK      = 3'd0;
    localparam logic [2:0] OP_OPEN      = 3'd1;
    localparam logic [2:0] OP_CLOSE     = 3'd2;
    localparam logic [2:0] OP_CLOSE_ALL = 3'd3;
    localparam logic [2:0] OP_RESUME    = 3'd4;

    // command status
    localparam logic [2:0] ST_DONE      = 3'd0;
    localparam logic [2:0] ST_NO_CHANGE = 3'd1;
    localparam logic [2:0] ST_DEFERRED  = 3'd2;
    localparam logic [2:0] ST_ALARM     = 3'd3;
    localparam logic [2:0] ST_INVALID   = 3'd4;
    localparam logic [2:0] ST_BUSY      = 3'd5;

    // per-channel move outcome
    localparam logic [1:0] MV_CHANGED   = 2'd0;
    localparam logic [1:0] MV_NO_CHANGE = 2'd1;
    localparam logic [1:0] MV_DEFERRED  = 2'd2;

    // register indexes
    localparam logic [2:0] REG_TRAVEL1   = 3'd0;
    localparam logic [2:0] REG_TRAVEL2   = 3'd1;
    localparam logic [2:0] REG_TRAVEL3   = 3'd2;
    localparam logic [2:0] REG_DWELL_OPN = 3'd3;
    localparam logic [2:0] REG_DWELL_CLS = 3'd4;
    localparam logic [2:0] REG_GAP       = 3'd5;
    localparam logic [2:0] REG_DEBOUNCE  = 3'd6;
    localparam logic [2:0] REG_GUARD     = 3'd7;

    typedef struct packed {
        logic [21:0] travel_ms_ch1;
        logic [21:0] travel_ms_ch2;
        logic [21:0] travel_ms_ch3;
        logic [21:0] rest_open_ms;
        logic [21:0] rest_close_ms;
        logic [15:0] reversal_gap_ms;
        logic [9:0]  debounce_ms;
        logic [17:0] guard_ms;
    } cfg_t;

    typedef struct packed {
        timer_t travel;
        timer_t rest_open;
        timer_t rest_close;
        timer_t gap;
    } chan_cfg_t;

    typedef struct packed {
        logic tick;
        logic move;
        logic dir_open;
        logic safe;
    } chan_op_t;

    typedef struct packed {
        logic [2:0] cmd;
        logic [2:0] channel;
        logic       safety_source;
        logic       alarm_level;
    } item_t;

    typedef struct packed {
        logic [2:0] open_relays;
        logic [2:0] close_relays;
        logic [2:0] state_one;
        logic [2:0] state_two;
        logic [2:0] state_three;
        logic       alarm_on;
        logic       calibrating;
        logic       guard_active;
        logic [2:0] cmd_status;
    } result_t;

    function automatic timer_t sat_timer(input logic [31:0] v);
        logic [31:0] w;
        w = (v > TMAX) ? TMAX : v;
        return w[TIMER_BITS-1:0];
    endfunction

endpackage

FILE: rtl/rmrs_if.sv
// stream interfaces for input items and result items
interface rmrs_item_if;
    import rmrs_pkg::*;
    logic       valid;
    logic       ready;
    logic [2:0] cmd;
    logic [2:0] channel;
    logic       safety_source;
    logic       alarm_level;

    modport source (output valid, cmd, channel, safety_source, alarm_level, input ready);
    modport sink   (input valid, cmd, channel, safety_source, alarm_level, output ready);
endinterface

interface rmrs_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] open_relays;
    logic [2:0] close_relays;
    logic [2:0] state_one;
    logic [2:0] state_two;
    logic [2:0] state_three;
    logic       alarm_on;
    logic       calibrating;
    logic       guard_active;
    logic [2:0] cmd_status;

    modport source (output valid, open_relays, close_relays, state_one, state_two,
                    state_three, alarm_on, calibrating, guard_active, cmd_status,
                    input ready);
    modport sink   (input valid, open_relays, close_relays, state_one, state_two,
                    state_three, alarm_on, calibrating, guard_active, cmd_status,
                    output ready);
endinterface

FILE: rtl/rmrs_cfg.sv
// apb register file holding the timing registers
module rmrs_cfg
    import rmrs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[4:2];
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.travel_ms_ch1   <= 22'd26000;
            cfg_reg.travel_ms_ch2   <= 22'd26000;
            cfg_reg.travel_ms_ch3   <= 22'd176000;
            cfg_reg.rest_open_ms    <= 22'd0;
            cfg_reg.rest_close_ms   <= 22'd0;
            cfg_reg.reversal_gap_ms <= 16'd2000;
            cfg_reg.debounce_ms     <= 10'd75;
            cfg_reg.guard_ms        <= 18'd60000;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_TRAVEL1:   cfg_reg.travel_ms_ch1   <= pwdata[21:0];
                REG_TRAVEL2:   cfg_reg.travel_ms_ch2   <= pwdata[21:0];
                REG_TRAVEL3:   cfg_reg.travel_ms_ch3   <= pwdata[21:0];
                REG_DWELL_OPN: cfg_reg.rest_open_ms    <= pwdata[21:0];
                REG_DWELL_CLS: cfg_reg.rest_close_ms   <= pwdata[21:0];
                REG_GAP:       cfg_reg.reversal_gap_ms <= pwdata[15:0];
                REG_DEBOUNCE:  cfg_reg.debounce_ms     <= pwdata[9:0];
                REG_GUARD:     cfg_reg.guard_ms        <= pwdata[17:0];
                default:       cfg_reg.guard_ms        <= cfg_reg.guard_ms;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_TRAVEL1:   prdata = 32'(cfg_reg.travel_ms_ch1);
            REG_TRAVEL2:   prdata = 32'(cfg_reg.travel_ms_ch2);
            REG_TRAVEL3:   prdata = 32'(cfg_reg.travel_ms_ch3);
            REG_DWELL_OPN: prdata = 32'(cfg_reg.rest_open_ms);
            REG_DWELL_CLS: prdata = 32'(cfg_reg.rest_close_ms);
            REG_GAP:       prdata = 32'(cfg_reg.reversal_gap_ms);
            REG_DEBOUNCE:  prdata = 32'(cfg_reg.debounce_ms);
            REG_GUARD:     prdata = 32'(cfg_reg.guard_ms);
            default:       prdata = 32'd0;
        endcase
    end

endmodule

FILE: rtl/rmrs_chan.sv
// next-state logic of one motor channel: tick advance or move request
module rmrs_chan
    import rmrs_pkg::*;
(
    input  mode_t      mode,
    input  timer_t     timer,
    input  chan_cfg_t  ccfg,
    input  chan_op_t   op,
    output mode_t      mode_next,
    output timer_t     timer_next,
    output logic [1:0] move_res
);

    always_comb
    begin
        timer_t t1;
        mode_t  at_m;
        mode_t  away_m;
        mode_t  mov_m;
        mode_t  back_m;
        mode_t  gap_m;
        mode_t  gap_back_m;

        mode_next  = mode;
        timer_next = timer;
        move_res   = MV_NO_CHANGE;
        t1         = (timer != '0) ? timer - timer_t'(1) : timer;

        at_m       = op.dir_open ? M_OPEN      : M_CLOSED;
        away_m     = op.dir_open ? M_CLOSED    : M_OPEN;
        mov_m      = op.dir_open ? M_MOV_OPEN  : M_MOV_CLOSE;
        back_m     = op.dir_open ? M_MOV_CLOSE : M_MOV_OPEN;
        gap_m      = op.dir_open ? M_GAP_OPEN  : M_GAP_CLOSE;
        gap_back_m = op.dir_open ? M_GAP_CLOSE : M_GAP_OPEN;

        if (op.tick)
        begin
            if (mode != M_UNKNOWN && mode <= M_GAP_CLOSE)
            begin
                timer_next = t1;
                // timer ran out on this tick: take the follow-on state
                if (t1 == '0 && mode != M_OPEN && mode != M_CLOSED)
                begin
                    case (mode)
                        M_MOV_OPEN:
                        begin
                            mode_next  = M_OPEN;
                            timer_next = ccfg.rest_open;
                        end
                        M_MOV_CLOSE:
                        begin
                            mode_next  = M_CLOSED;
                            timer_next = ccfg.rest_close;
                        end
                        M_GAP_OPEN:
                        begin
                            mode_next  = M_MOV_OPEN;
                            timer_next = ccfg.travel;
                        end
                        default:
                        begin
                            mode_next  = M_MOV_CLOSE;
                            timer_next = ccfg.travel;
                        end
                    endcase
                end
            end
        end
        else if (op.move)
        begin
            if (mode == at_m || mode == mov_m || mode == gap_m)
            begin
                move_res = MV_NO_CHANGE;
            end
            else if (mode == back_m)
            begin
                mode_next  = gap_m;
                timer_next = ccfg.gap;
                move_res   = MV_CHANGED;
            end
            else if (mode == gap_back_m)
            begin
                // pivot inside the gap keeps the running gap time
                mode_next = gap_m;
                move_res  = MV_CHANGED;
            end
            else if (mode == away_m && !op.safe && timer != '0)
            begin
                move_res = MV_DEFERRED;
            end
            else
            begin
                mode_next  = mov_m;
                timer_next = ccfg.travel;
                move_res   = MV_CHANGED;
            end
        end
    end

endmodule

FILE: rtl/reversing_motor_relay_sequencer_top.sv
// top level of the reversing motor relay sequencer
//
//   port          dir   role
//   item_in       sink  tick or command beat with alarm pin level
//   result_out    src   relay drive, channel states, flags, command status
//   apb           sink  timing registers, 4-byte stride
//
// one beat accepted per cycle while the result side is not stalled; the result is
// registered once its beat leaves the input register (input register, then one
// combinational pass that updates all state and loads the result register)
// the first beat after reset samples the alarm pin and either latches the
// alarm or starts the close-all calibration
// a stalled result holds the result register; the input register still
// takes a beat, and item_in.ready drops only when both stages are full
// asynchronous active-low reset clears all control state and timers
module reversing_motor_relay_sequencer_top
    import rmrs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    rmrs_item_if.sink     item_in,
    rmrs_result_if.source result_out
);

`include "reversing_motor_relay_sequencer_top_macros.svh"

    cfg_t cfg;

    rmrs_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // pipeline registers
    logic    a_valid_reg;
    item_t   a_item_reg;
    logic    out_valid_reg;
    result_t out_reg;
    logic    a_fire;

    assign a_fire        = a_valid_reg && (!out_valid_reg || result_out.ready);
    assign item_in.ready = !a_valid_reg || a_fire;

    // sequencer state
    mode_t      mode_reg   [CHANNELS];
    timer_t     timer_reg  [CHANNELS];
    logic       latched_reg;
    logic       last_lvl_reg;
    logic       pend_reg;
    logic [9:0] dt_reg;
    logic [17:0] guard_reg;
    logic [1:0] phase_reg;

    mode_t      mode_next  [CHANNELS];
    timer_t     timer_next [CHANNELS];
    logic       latched_next;
    logic       last_lvl_next;
    logic       pend_next;
    logic [9:0] dt_next;
    logic [17:0] guard_next;
    logic [1:0] phase_next;
    result_t    res_next;

    // state after the boot sample, fed to the channel logic
    mode_t      mode_b     [CHANNELS];
    timer_t     timer_b    [CHANNELS];
    logic       latched_b;
    logic [1:0] phase_b;
    logic [17:0] guard_b;
    logic       booted;
    logic       cmd_ok;

    chan_cfg_t  ccfg       [CHANNELS];
    chan_op_t   cop        [CHANNELS];
    mode_t      ch_mode    [CHANNELS];
    timer_t     ch_timer   [CHANNELS];
    logic [1:0] ch_res     [CHANNELS];

    logic       is_tick;
    logic       lvl;

    assign is_tick = (a_item_reg.cmd == OP_TICK);
    assign lvl     = a_item_reg.alarm_level;
    assign booted  = (phase_reg == PH_BOOT);

    always_comb
    begin
        latched_b = booted ? lvl : latched_reg;
        phase_b   = booted ? (lvl ? PH_NORMAL : PH_CALIB) : phase_reg;
        guard_b   = booted ? 18'd0 : guard_reg;
        for (int c = 0; c < CHANNELS; c++)
        begin
            if (booted)
            begin
                mode_b[c]  = lvl ? M_UNKNOWN : M_MOV_CLOSE;
                timer_b[c] = lvl ? '0 : ccfg[c].travel;
            end
            else
            begin
                mode_b[c]  = mode_reg[c];
                timer_b[c] = timer_reg[c];
            end
        end
    end

    assign cmd_ok = !latched_b && (phase_b == PH_NORMAL);

    genvar g;
    generate
        for (g = 0; g < CHANNELS; g++)
        begin : gen_chan
            logic [21:0] travel_raw;
            logic        sel;

            if (g == 0)
            begin : gen_t1
                assign travel_raw = cfg.travel_ms_ch1;
            end
            else if (g == 1)
            begin : gen_t2
                assign travel_raw = cfg.travel_ms_ch2;
            end
            else
            begin : gen_t3
                assign travel_raw = cfg.travel_ms_ch3;
            end

            assign ccfg[g].travel     = sat_timer(32'(travel_raw));
            assign ccfg[g].rest_open  = sat_timer(32'(cfg.rest_open_ms));
            assign ccfg[g].rest_close = sat_timer(32'(cfg.rest_close_ms));
            assign ccfg[g].gap        = sat_timer(32'(cfg.reversal_gap_ms));

            assign sel = (a_item_reg.cmd == OP_CLOSE_ALL) ||
                         (((a_item_reg.cmd == OP_OPEN) || (a_item_reg.cmd == OP_CLOSE)) &&
                          ({1'b0, a_item_reg.channel} == 4'(g + 1)));

            assign cop[g].tick     = is_tick && !booted;
            assign cop[g].move     = !is_tick && cmd_ok && sel;
            assign cop[g].dir_open = (a_item_reg.cmd == OP_OPEN);
            assign cop[g].safe     = a_item_reg.safety_source;

            rmrs_chan u_chan (
                .mode       (mode_b[g]),
                .timer      (timer_b[g]),
                .ccfg       (ccfg[g]),
                .op         (cop[g]),
                .mode_next  (ch_mode[g]),
                .timer_next (ch_timer[g]),
                .move_res   (ch_res[g])
            );
        end
    endgenerate

    localparam logic [1:0] OVR_NONE  = 2'd0;
    localparam logic [1:0] OVR_ONSET = 2'd1;
    localparam logic [1:0] OVR_CALIB = 2'd2;

    always_comb
    begin
        logic        edge_seen;
        logic        any_mc;
        logic        changed;
        logic        deferred;
        logic        ch_valid;
        logic [1:0]  ovr;
        logic [17:0] gdec;
        logic [2:0]  status;
        logic [2:0]  vis [3];
        logic [2:0]  orel;
        logic [2:0]  crel;

        edge_seen    = booted ? 1'b0 : (lvl != last_lvl_reg);
        last_lvl_next = lvl;
        latched_next = latched_b;
        phase_next   = phase_b;
        guard_next   = guard_b;
        pend_next    = pend_reg;
        dt_next      = dt_reg;
        ovr          = OVR_NONE;
        status       = ST_DONE;
        any_mc       = 1'b0;
        changed      = 1'b0;
        deferred     = 1'b0;
        ch_valid     = 1'b0;
        gdec         = 18'd0;

        for (int c = 0; c < CHANNELS; c++)
        begin
            if (ch_mode[c] == M_MOV_CLOSE)
                any_mc = 1'b1;
            if (ch_res[c] == MV_CHANGED)
                changed = 1'b1;
            if (ch_res[c] == MV_DEFERRED)
                deferred = 1'b1;
        end

        if (is_tick)
        begin
            if (!booted)
            begin
                if (phase_next == PH_CALIB && !any_mc)
                    phase_next = PH_NORMAL;
                if (phase_next == PH_GUARD)
                begin
                    gdec       = (guard_next != 18'd0) ? guard_next - 18'd1 : guard_next;
                    guard_next = gdec;
                    if (gdec == 18'd0)
                    begin
                        if (lvl)
                        begin
                            latched_next = 1'b1;
                            guard_next   = 18'd0;
                            phase_next   = PH_NORMAL;
                            ovr          = OVR_ONSET;
                        end
                        else
                        begin
                            phase_next = PH_CALIB;
                            ovr        = OVR_CALIB;
                        end
                    end
                end
            end
            if (edge_seen)
            begin
                pend_next = 1'b1;
                dt_next   = cfg.debounce_ms;
            end
            else if (pend_next && dt_next != 10'd0)
            begin
                dt_next = dt_next - 10'd1;
            end
            // level confirmed
            if (pend_next && dt_next == 10'd0)
            begin
                pend_next = 1'b0;
                if (lvl && !latched_next)
                begin
                    latched_next = 1'b1;
                    guard_next   = 18'd0;
                    phase_next   = PH_NORMAL;
                    ovr          = OVR_ONSET;
                end
                else if (!lvl && latched_next)
                begin
                    latched_next = 1'b0;
                    if (cfg.guard_ms == 18'd0)
                    begin
                        phase_next = PH_CALIB;
                        ovr        = OVR_CALIB;
                    end
                    else
                    begin
                        guard_next = cfg.guard_ms;
                        phase_next = PH_GUARD;
                    end
                end
            end
        end
        else
        begin
            if (edge_seen)
            begin
                pend_next = 1'b1;
                dt_next   = cfg.debounce_ms;
            end
            ch_valid = (a_item_reg.channel != 3'd0) &&
                       ({1'b0, a_item_reg.channel} <= 4'(CHANNELS));
            if (latched_b)
                status = ST_ALARM;
            else if (phase_b == PH_GUARD || phase_b == PH_CALIB)
                status = ST_BUSY;
            else
            begin
                case (a_item_reg.cmd)
                    OP_RESUME:
                        status = ST_DONE;
                    OP_CLOSE_ALL:
                        status = changed ? ST_DONE : (deferred ? ST_DEFERRED : ST_NO_CHANGE);
                    OP_OPEN, OP_CLOSE:
                    begin
                        if (!ch_valid)
                            status = ST_INVALID;
                        else
                            status = changed ? ST_DONE :
                                     (deferred ? ST_DEFERRED : ST_NO_CHANGE);
                    end
                    default:
                        status = ST_INVALID;
                endcase
            end
        end

        for (int c = 0; c < CHANNELS; c++)
        begin
            case (ovr)
                OVR_ONSET:
                begin
                    mode_next[c]  = M_UNKNOWN;
                    timer_next[c] = '0;
                end
                OVR_CALIB:
                begin
                    mode_next[c]  = M_MOV_CLOSE;
                    timer_next[c] = ccfg[c].travel;
                end
                default:
                begin
                    mode_next[c]  = ch_mode[c];
                    timer_next[c] = ch_timer[c];
                end
            endcase
        end

        // channels beyond the count show unknown
        for (int c = 0; c < 3; c++)
            vis[c] = (c < CHANNELS) ? mode_next[c % CHANNELS] : M_UNKNOWN;
        for (int c = 0; c < 3; c++)
        begin
            orel[c] = (vis[c] == M_MOV_OPEN);
            crel[c] = (vis[c] == M_MOV_CLOSE);
        end

        res_next.open_relays  = orel;
        res_next.close_relays = crel;
        res_next.state_one    = vis[0];
        res_next.state_two    = vis[1];
        res_next.state_three  = vis[2];
        res_next.alarm_on     = latched_next;
        res_next.calibrating  = (phase_next == PH_CALIB);
        res_next.guard_active = (phase_next == PH_GUARD);
        res_next.cmd_status   = status;
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            latched_reg   <= 1'b0;
            last_lvl_reg  <= 1'b0;
            pend_reg      <= 1'b0;
            dt_reg        <= 10'd0;
            guard_reg     <= 18'd0;
            phase_reg     <= PH_BOOT;
            for (int c = 0; c < CHANNELS; c++)
            begin
                mode_reg[c]  <= M_UNKNOWN;
                timer_reg[c] <= '0;
            end
        end
        else
        begin
            if (item_in.ready)
                a_valid_reg <= item_in.valid;
            if (a_fire)
                out_valid_reg <= 1'b1;
            else if (result_out.ready)
                out_valid_reg <= 1'b0;
            if (a_fire)
            begin
                latched_reg  <= latched_next;
                last_lvl_reg <= last_lvl_next;
                pend_reg     <= pend_next;
                dt_reg       <= dt_next;
                guard_reg    <= guard_next;
                phase_reg    <= phase_next;
                for (int c = 0; c < CHANNELS; c++)
                begin
                    mode_reg[c]  <= mode_next[c];
                    timer_reg[c] <= timer_next[c];
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (item_in.valid && item_in.ready)
        begin
            a_item_reg.cmd           <= item_in.cmd;
            a_item_reg.channel       <= item_in.channel;
            a_item_reg.safety_source <= item_in.safety_source;
            a_item_reg.alarm_level   <= item_in.alarm_level;
        end
        if (a_fire)
            out_reg <= res_next;
    end

    assign result_out.valid        = out_valid_reg;
    assign result_out.open_relays  = out_reg.open_relays;
    assign result_out.close_relays = out_reg.close_relays;
    assign result_out.state_one    = out_reg.state_one;
    assign result_out.state_two    = out_reg.state_two;
    assign result_out.state_three  = out_reg.state_three;
    assign result_out.alarm_on     = out_reg.alarm_on;
    assign result_out.calibrating  = out_reg.calibrating;
    assign result_out.guard_active = out_reg.guard_active;
    assign result_out.cmd_status   = out_reg.cmd_status;

    // a latched alarm leaves every channel unknown; only the first channel is checked here
    `RMRS_ASSERT_IMPL(a_latched_unknown, latched_reg, mode_reg[0] == M_UNKNOWN)
    // guard wait only runs after clearance
    `RMRS_ASSERT_IMPL(a_guard_unlatched, phase_reg == PH_GUARD, !latched_reg)
    // never both relays of one channel
    `RMRS_ASSERT_IMPL(a_relay_excl, out_valid_reg, ~|(out_reg.open_relays & out_reg.close_relays))
    // state moves only with a processed beat
    `RMRS_ASSERT_NEXT(a_state_hold, !a_fire, $stable(phase_reg) && $stable(latched_reg))

endmodule

FILE: sim/rmrs_relay_checker.sv
`timescale 1ns / 1ps
// relay sequencer checker: watches the register port and both streams, predicts and compares
module rmrs_relay_checker
    import rmrs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    rmrs_item_if        items,
    rmrs_result_if      results,
    output int          fail_count,
    output int          pending
);

    logic [31:0] ms_reg [8];
    mode_t       ch_mode [CHANNELS];
    timer_t      ch_timer [CHANNELS];
    logic        alarm_held;
    logic        pin_seen;
    logic        debounce_armed;
    logic [9:0]  debounce_left;
    logic [17:0] guard_left;
    logic [1:0]  phase;
    result_t     relay_reports_q[$];

    function automatic timer_t travel_ms(int c);
        case (c)
            0:       return timer_t'(ms_reg[REG_TRAVEL1]);
            1:       return timer_t'(ms_reg[REG_TRAVEL2]);
            default: return timer_t'(ms_reg[REG_TRAVEL3]);
        endcase
    endfunction

    function automatic void latch_alarm();
        alarm_held = 1'b1;
        for (int c = 0; c < CHANNELS; c++)
        begin
            ch_mode[c]  = M_UNKNOWN;
            ch_timer[c] = '0;
        end
        guard_left = '0;
        phase      = PH_NORMAL;
    endfunction

    function automatic void start_calib(logic lvl);
        if (lvl)
        begin
            latch_alarm();
            return;
        end
        for (int c = 0; c < CHANNELS; c++)
        begin
            ch_mode[c]  = M_MOV_CLOSE;
            ch_timer[c] = travel_ms(c);
        end
        phase = PH_CALIB;
    endfunction

    function automatic void tick_channel(int c);
        mode_t m;
        m = ch_mode[c];
        if (m == M_UNKNOWN || m > M_GAP_CLOSE)
            return;
        if (ch_timer[c] != 0)
            ch_timer[c] = ch_timer[c] - 1'b1;
        if (ch_timer[c] != 0 || m == M_OPEN || m == M_CLOSED)
            return;
        case (m)
            M_MOV_OPEN:
            begin
                ch_mode[c]  = M_OPEN;
                ch_timer[c] = timer_t'(ms_reg[REG_DWELL_OPN]);
            end
            M_MOV_CLOSE:
            begin
                ch_mode[c]  = M_CLOSED;
                ch_timer[c] = timer_t'(ms_reg[REG_DWELL_CLS]);
            end
            M_GAP_OPEN:
            begin
                ch_mode[c]  = M_MOV_OPEN;
                ch_timer[c] = travel_ms(c);
            end
            default:
            begin
                ch_mode[c]  = M_MOV_CLOSE;
                ch_timer[c] = travel_ms(c);
            end
        endcase
    endfunction

    function automatic logic [1:0] request_move(int c, logic to_open, logic safe);
        mode_t m, at, away, mov, mov_back, gap, gap_back;
        m        = ch_mode[c];
        at       = to_open ? M_OPEN : M_CLOSED;
        away     = to_open ? M_CLOSED : M_OPEN;
        mov      = to_open ? M_MOV_OPEN : M_MOV_CLOSE;
        mov_back = to_open ? M_MOV_CLOSE : M_MOV_OPEN;
        gap      = to_open ? M_GAP_OPEN : M_GAP_CLOSE;
        gap_back = to_open ? M_GAP_CLOSE : M_GAP_OPEN;
        if (m == at || m == mov || m == gap)
            return MV_NO_CHANGE;
        // reversal drops both relays for the gap time
        if (m == mov_back)
        begin
            ch_mode[c]  = gap;
            ch_timer[c] = timer_t'(ms_reg[REG_GAP]);
            return MV_CHANGED;
        end
        // direction change inside a running gap keeps the gap timer
        if (m == gap_back)
        begin
            ch_mode[c] = gap;
            return MV_CHANGED;
        end
        if (m == away && !safe && ch_timer[c] != 0)
            return MV_DEFERRED;
        ch_mode[c]  = mov;
        ch_timer[c] = travel_ms(c);
        return MV_CHANGED;
    endfunction

    function automatic logic [2:0] apply_command(logic [2:0] cmd, logic [2:0] ch, logic safe);
        logic       changed, deferred;
        logic [1:0] mv;
        changed  = 1'b0;
        deferred = 1'b0;
        if (alarm_held)
            return ST_ALARM;
        if (phase == PH_GUARD || phase == PH_CALIB)
            return ST_BUSY;
        if (cmd == OP_RESUME)
            return ST_DONE;
        if (cmd == OP_CLOSE_ALL)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                mv = request_move(c, 1'b0, safe);
                if (mv == MV_CHANGED)
                    changed = 1'b1;
                if (mv == MV_DEFERRED)
                    deferred = 1'b1;
            end
            return changed ? ST_DONE : (deferred ? ST_DEFERRED : ST_NO_CHANGE);
        end
        if (cmd == OP_OPEN || cmd == OP_CLOSE)
        begin
            if (ch < 1 || ch > CHANNELS)
                return ST_INVALID;
            mv = request_move(int'(ch) - 1, cmd == OP_OPEN, safe);
            case (mv)
                MV_CHANGED:   return ST_DONE;
                MV_NO_CHANGE: return ST_NO_CHANGE;
                default:      return ST_DEFERRED;
            endcase
        end
        return ST_INVALID;
    endfunction

    function automatic result_t next_relay_state(item_t it);
        logic    booted, pin_changed, calib_busy;
        result_t r;
        booted = 1'b0;
        r      = '0;
        // first beat after reset samples the pin
        if (phase == PH_BOOT)
        begin
            pin_seen = it.alarm_level;
            booted   = 1'b1;
            if (it.alarm_level)
                latch_alarm();
            else
                start_calib(1'b0);
        end
        pin_changed = it.alarm_level != pin_seen;
        pin_seen    = it.alarm_level;

        if (it.cmd == OP_TICK)
        begin
            if (!booted)
            begin
                for (int c = 0; c < CHANNELS; c++)
                    tick_channel(c);
                if (phase == PH_CALIB)
                begin
                    calib_busy = 1'b0;
                    for (int c = 0; c < CHANNELS; c++)
                        if (ch_mode[c] == M_MOV_CLOSE)
                            calib_busy = 1'b1;
                    if (!calib_busy)
                        phase = PH_NORMAL;
                end
                if (phase == PH_GUARD)
                begin
                    if (guard_left != 0)
                        guard_left = guard_left - 1'b1;
                    if (guard_left == 0)
                        start_calib(it.alarm_level);
                end
            end
            if (pin_changed)
            begin
                debounce_armed = 1'b1;
                debounce_left  = ms_reg[REG_DEBOUNCE][9:0];
            end
            else if (debounce_armed && debounce_left != 0)
                debounce_left = debounce_left - 1'b1;
            if (debounce_armed && debounce_left == 0)
            begin
                debounce_armed = 1'b0;
                if (it.alarm_level && !alarm_held)
                    latch_alarm();
                else if (!it.alarm_level && alarm_held)
                begin
                    alarm_held = 1'b0;
                    if (ms_reg[REG_GUARD] == 0)
                        start_calib(it.alarm_level);
                    else
                    begin
                        guard_left = ms_reg[REG_GUARD][17:0];
                        phase      = PH_GUARD;
                    end
                end
            end
            r.cmd_status = ST_DONE;
        end
        else
        begin
            if (pin_changed)
            begin
                debounce_armed = 1'b1;
                debounce_left  = ms_reg[REG_DEBOUNCE][9:0];
            end
            r.cmd_status = apply_command(it.cmd, it.channel, it.safety_source);
        end

        for (int c = 0; c < CHANNELS && c < 3; c++)
        begin
            if (ch_mode[c] == M_MOV_OPEN)
                r.open_relays[c] = 1'b1;
            if (ch_mode[c] == M_MOV_CLOSE)
                r.close_relays[c] = 1'b1;
        end
        r.state_one    = ch_mode[0];
        r.state_two    = ch_mode[1];
        r.state_three  = ch_mode[2];
        r.alarm_on     = alarm_held;
        r.calibrating  = phase == PH_CALIB;
        r.guard_active = phase == PH_GUARD;
        return r;
    endfunction

    function automatic void report_field(string name, logic [31:0] want_v, logic [31:0] got_v);
        if (got_v !== want_v)
        begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        item_t   beat;
        result_t want;
        if (!rst_n)
        begin
            ms_reg[REG_TRAVEL1]   = 32'd26000;
            ms_reg[REG_TRAVEL2]   = 32'd26000;
            ms_reg[REG_TRAVEL3]   = 32'd176000;
            ms_reg[REG_DWELL_OPN] = 32'd0;
            ms_reg[REG_DWELL_CLS] = 32'd0;
            ms_reg[REG_GAP]       = 32'd2000;
            ms_reg[REG_DEBOUNCE]  = 32'd75;
            ms_reg[REG_GUARD]     = 32'd60000;
            for (int c = 0; c < CHANNELS; c++)
            begin
                ch_mode[c]  = M_UNKNOWN;
                ch_timer[c] = '0;
            end
            alarm_held     = 1'b0;
            pin_seen       = 1'b0;
            debounce_armed = 1'b0;
            debounce_left  = '0;
            guard_left     = '0;
            phase          = PH_BOOT;
            relay_reports_q.delete();
            pending = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[4:2])
                    REG_GAP:      ms_reg[paddr[4:2]] = pwdata & 32'h0000_FFFF;
                    REG_DEBOUNCE: ms_reg[paddr[4:2]] = pwdata & 32'h0000_03FF;
                    REG_GUARD:    ms_reg[paddr[4:2]] = pwdata & 32'h0003_FFFF;
                    default:      ms_reg[paddr[4:2]] = pwdata & 32'h003F_FFFF;
                endcase
            end
            // the result leaving now belongs to an older beat, so check before pushing
            if (results.valid && results.ready)
            begin
                if (relay_reports_q.size() == 0)
                begin
                    $error("result beat with no expectation pending");
                    fail_count++;
                end
                else
                begin
                    want = relay_reports_q.pop_front();
                    report_field("open_relays", 32'(want.open_relays),
                                 32'(results.open_relays));
                    report_field("close_relays", 32'(want.close_relays),
                                 32'(results.close_relays));
                    report_field("state_one", 32'(want.state_one), 32'(results.state_one));
                    report_field("state_two", 32'(want.state_two), 32'(results.state_two));
                    report_field("state_three", 32'(want.state_three),
                                 32'(results.state_three));
                    report_field("alarm_on", 32'(want.alarm_on), 32'(results.alarm_on));
                    report_field("calibrating", 32'(want.calibrating),
                                 32'(results.calibrating));
                    report_field("guard_active", 32'(want.guard_active),
                                 32'(results.guard_active));
                    report_field("cmd_status", 32'(want.cmd_status), 32'(results.cmd_status));
                end
            end
            if (items.valid && items.ready)
            begin
                beat.cmd           = items.cmd;
                beat.channel       = items.channel;
                beat.safety_source = items.safety_source;
                beat.alarm_level   = items.alarm_level;
                relay_reports_q.push_back(next_relay_state(beat));
            end
            pending = relay_reports_q.size();
        end
    end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// testbench top: clock, reset, register setup, stimulus and verdict for the relay sequencer
module tb;
    import rmrs_pkg::*;

    localparam int LIMIT       = 500000;
    localparam int PHASE_ITEMS = 240;
    localparam int TOP_ITEMS   = 100;

    // highest command code, outside the defined set
    localparam logic [2:0] OP_LAST = 3'd7;

    // register profiles
    localparam int CFG_SMALL = 0;
    localparam int CFG_ZERO  = 1;
    localparam int CFG_TOP   = 2;
    localparam int CFG_MIXED = 3;

    localparam int PROFILES [7] = '{CFG_SMALL, CFG_ZERO, CFG_SMALL, CFG_TOP,
                                    CFG_SMALL, CFG_MIXED, CFG_SMALL};

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;
    int          cycle_count = 0;
    logic        pin_lvl;
    logic        steady;

    rmrs_item_if   item_bus ();
    rmrs_result_if result_bus ();

    reversing_motor_relay_sequencer_top DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .item_in    (item_bus),
        .result_out (result_bus)
    );

    rmrs_relay_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .items      (item_bus),
        .results    (result_bus),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT)
        begin
            $display("reversing_motor_relay_sequencer_top: mismatch");
            $finish;
        end
    end

    // mostly short gaps, a few long ones, none while steady
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    function automatic logic [31:0] pick_ms(int kind, logic [31:0] top, int small_hi);
        case (kind)
            CFG_ZERO:  return '0;
            CFG_TOP:   return top;
            CFG_SMALL: return $urandom_range(0, small_hi);
            default:
            begin
                case ($urandom_range(0, 3))
                    0:       return '0;
                    1:       return top;
                    default: return $urandom_range(0, small_hi);
                endcase
            end
        endcase
    endfunction

    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apply_profile(input int kind);
        cfg_write(REG_TRAVEL1, pick_ms(kind, 32'h003F_FFFF, 8));
        cfg_write(REG_TRAVEL2, pick_ms(kind, 32'h003F_FFFF, 8));
        cfg_write(REG_TRAVEL3, pick_ms(kind, 32'h003F_FFFF, 8));
        cfg_write(REG_DWELL_OPN, pick_ms(kind, 32'h003F_FFFF, 6));
        cfg_write(REG_DWELL_CLS, pick_ms(kind, 32'h003F_FFFF, 6));
        cfg_write(REG_GAP, pick_ms(kind, 32'h0000_FFFF, 4));
        cfg_write(REG_DEBOUNCE, pick_ms(kind, 32'h0000_03FF, 3));
        cfg_write(REG_GUARD, pick_ms(kind, 32'h0003_FFFF, 6));
    endtask

    task automatic send_item(input logic [2:0] cmd, input logic [2:0] ch,
                             input logic safe, input logic lvl);
        int gap_len;
        gap_len = idle_len();
        @(negedge clk);
        if (gap_len > 0)
        begin
            item_bus.valid <= 1'b0;
            repeat (gap_len) @(negedge clk);
        end
        item_bus.valid         <= 1'b1;
        item_bus.cmd           <= cmd;
        item_bus.channel       <= ch;
        item_bus.safety_source <= safe;
        item_bus.alarm_level   <= lvl;
        @(posedge clk);
        while (!item_bus.ready)
            @(posedge clk);
    endtask

    // stop sending and wait until every result has come back
    task automatic drain();
        @(negedge clk);
        item_bus.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    task automatic random_item();
        int         r;
        logic [2:0] cmd;
        logic [2:0] ch;
        logic       lvl;
        // alarm pin: rare onsets, short alarms, an occasional one-beat glitch
        if (!pin_lvl)
        begin
            if ($urandom_range(0, 149) == 0)
                pin_lvl = 1'b1;
        end
        else if ($urandom_range(0, 14) == 0)
            pin_lvl = 1'b0;
        lvl = pin_lvl;
        if ($urandom_range(0, 79) == 0)
            lvl = !pin_lvl;
        ch = 3'($urandom_range(1, 3));
        if ($urandom_range(0, 9) == 0)
            ch = 3'($urandom_range(0, 7));
        r = $urandom_range(0, 99);
        if (r < 45)
            cmd = OP_TICK;
        else if (r < 63)
            cmd = OP_OPEN;
        else if (r < 81)
            cmd = OP_CLOSE;
        else if (r < 89)
            cmd = OP_CLOSE_ALL;
        else if (r < 94)
            cmd = OP_RESUME;
        else
            cmd = 3'($urandom_range(OP_RESUME + 3'd1, OP_LAST));
        send_item(cmd, ch, $urandom_range(0, 3) == 0, lvl);
    endtask

    initial
    begin : sink_side
        int run;
        result_bus.ready = 1'b0;
        forever
        begin
            run = $urandom_range(1, 40);
            repeat (run)
            begin
                @(negedge clk);
                result_bus.ready <= 1'b1;
            end
            run = idle_len();
            repeat (run)
            begin
                @(negedge clk);
                result_bus.ready <= 1'b0;
            end
        end
    end

    initial
    begin : stimulus
        logic boot_lvl;
        int   n;
        rst_n                  = 1'b0;
        psel                   = 1'b0;
        penable                = 1'b0;
        pwrite                 = 1'b0;
        paddr                  = '0;
        pwdata                 = '0;
        item_bus.valid         = 1'b0;
        item_bus.cmd           = OP_TICK;
        item_bus.channel       = '0;
        item_bus.safety_source = 1'b0;
        item_bus.alarm_level   = 1'b0;
        pin_lvl                = 1'b0;
        steady                 = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        cfg_write(REG_TRAVEL1, 32'd4);
        cfg_write(REG_TRAVEL2, 32'd6);
        cfg_write(REG_TRAVEL3, 32'd0);
        cfg_write(REG_DWELL_OPN, 32'd3);
        cfg_write(REG_DWELL_CLS, 32'd2);
        cfg_write(REG_GAP, 32'd2);
        cfg_write(REG_DEBOUNCE, 32'd1);
        cfg_write(REG_GUARD, 32'd3);

        // boot either into calibration or straight into an alarm
        boot_lvl = 1'($urandom_range(0, 1));
        send_item(OP_TICK, 3'd1, 1'b0, boot_lvl);
        send_item(OP_OPEN, 3'd1, 1'b0, 1'b0);
        repeat (14) send_item(OP_TICK, 3'd2, 1'b0, 1'b0);
        send_item(OP_CLOSE, 3'd1, 1'b0, 1'b0);
        send_item(OP_OPEN, 3'd1, 1'b0, 1'b0);
        send_item(OP_CLOSE, 3'd1, 1'b0, 1'b0);
        send_item(OP_OPEN, 3'd1, 1'b1, 1'b0);
        send_item(OP_OPEN, 3'd0, 1'b0, 1'b0);
        send_item(OP_CLOSE, 3'd7, 1'b0, 1'b0);
        send_item(OP_LAST, 3'd4, 1'b1, 1'b0);
        send_item(OP_RESUME, 3'd3, 1'b0, 1'b0);
        send_item(OP_CLOSE_ALL, 3'd5, 1'b0, 1'b0);
        // alarm onset, command under alarm, clearance, command during guard
        send_item(OP_TICK, 3'd6, 1'b0, 1'b1);
        send_item(OP_TICK, 3'd1, 1'b0, 1'b1);
        send_item(OP_OPEN, 3'd2, 1'b0, 1'b1);
        send_item(OP_TICK, 3'd1, 1'b0, 1'b0);
        send_item(OP_TICK, 3'd1, 1'b0, 1'b0);
        send_item(OP_CLOSE_ALL, 3'd3, 1'b1, 1'b0);
        drain();

        foreach (PROFILES[p])
        begin
            apply_profile(PROFILES[p]);
            n = (PROFILES[p] == CFG_TOP) ? TOP_ITEMS : PHASE_ITEMS;
            steady = 1'b0;
            for (int i = 0; i < n; i++)
            begin
                if (i % 60 == 59)
                    steady = ($urandom_range(0, 3) == 0);
                random_item();
            end
            drain();
        end

        repeat (10) @(negedge clk);
        if (fail_count == 0)
            $display("reversing_motor_relay_sequencer_top: match");
        else
            $display("reversing_motor_relay_sequencer_top: mismatch");
        $finish;
    end

endmodule
